// ----- sv/thl_pkg.sv -----
// thl_pkg: shared constants, types and codes of the tree hierarchical lock unit
// used by every module of the block; depends on nothing
`default_nettype none

package thl_pkg;

   localparam int MAX_NODES     = 1024;
   localparam int NODE_BITS     = 10;
   localparam int SWEEP_BITS    = NODE_BITS + 1;
   localparam int COUNT_BITS    = 11;
   localparam int LIMIT_BITS    = 11;
   localparam int BRANCH_BITS   = 10;
   localparam int USER_BITS     = 16;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [BRANCH_BITS-1:0] BRANCHING_RESET  = BRANCH_BITS'(2);
   localparam logic [LIMIT_BITS-1:0]  NODE_COUNT_RESET = LIMIT_BITS'(MAX_NODES);

   // request kinds
   localparam logic KIND_LOCK   = 1'b0;
   localparam logic KIND_UNLOCK = 1'b1;

   // register index, taken from paddr bit 2
   typedef enum logic {
      REG_BRANCHING  = 1'b0,
      REG_NODE_COUNT = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [BRANCH_BITS-1:0] branching;
      logic [LIMIT_BITS-1:0]  node_count;
      logic                   rebuild;
   } cfg_type;

   // one entry of the node table
   typedef struct packed {
      logic [NODE_BITS-1:0]  parent;
      logic                  held;
      logic [COUNT_BITS-1:0] count;
   } node_word_type;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_FIRST,
      ST_CHECK,
      ST_ADJUST,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

// ----- sv/tree_hierarchical_lock_unit.sv -----
// tree hierarchical lock unit: lock and unlock of nodes in a heap-ordered m-ary tree
// top level, ties the register file to the walk engine; depends on thl_pkg,
// thl_csr, thl_engine
//
// request channel (req_): one beat is one lock (kind 0) or unlock (kind 1) of
//   node_index on behalf of user_id; one request is in work at a time
// response channel (rsp_): one beat per request, granted 1 on success
// registers over apb: branching at 0x0, node_count at 0x4
// walk from request beat to response valid:
//   lock: check the node, then each ancestor up to the root, then walk
//   again from the node to the root to count it in; unlock: one walk up
//   the walk reads one node table entry per cycle over a single read port;
//   refused and out-of-range requests end early, and req_stall drops in
//   the same cycle as the response is raised
// reset: the node table is cleared and its parent links built in a sweep
//   over all entries, req_stall stays high meanwhile; a write to branching starts
//   the same sweep (links only, locks kept)
// a stalled response stays in its output register while the next request is
//   taken; a finished walk waits only if that register is still full
`default_nettype none

module tree_hierarchical_lock_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_kind,
   input  wire logic [thl_pkg::NODE_BITS-1:0]     req_node_index,
   input  wire logic [thl_pkg::USER_BITS-1:0]     req_user_id,
   // response channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_granted,
   // apb register port
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [thl_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [thl_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic      [thl_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                                   pready
);
   import thl_pkg::*;

   // live configuration and the rebuild pulse
   cfg_type cfg;

   thl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // node table, owner memory and the check and count walks of each request
   thl_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_node_index (req_node_index),
      .req_user_id    (req_user_id),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_granted    (rsp_granted)
   );

endmodule

`default_nettype wire

// ----- sv/thl_csr.sv -----
// thl_csr: apb register file holding branching and node_count
// depends on thl_pkg
`default_nettype none

module thl_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [thl_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  wire logic [thl_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic      [thl_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                      pready,
   output thl_pkg::cfg_type                          cfg
);
   import thl_pkg::*;

   logic [BRANCH_BITS-1:0] branching_ff, branching_in;
   logic [LIMIT_BITS-1:0]  node_count_ff, node_count_in;
   logic                   wr_en;
   reg_index_type          sel;

   assign wr_en = psel & penable & pwrite;
   assign sel   = reg_index_type'(paddr[2]);

   always_comb begin
      branching_in  = branching_ff;
      node_count_in = node_count_ff;
      if (wr_en) begin
         case (sel)
            REG_BRANCHING:  branching_in  = pwdata[BRANCH_BITS-1:0];
            REG_NODE_COUNT: node_count_in = pwdata[LIMIT_BITS-1:0];
            default:        branching_in  = branching_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         branching_ff  <= BRANCHING_RESET;
         node_count_ff <= NODE_COUNT_RESET;
      end else begin
         branching_ff  <= branching_in;
         node_count_ff <= node_count_in;
      end
   end

   always_comb begin
      case (sel)
         REG_BRANCHING:  prdata = CSR_DATA_BITS'(branching_ff);
         REG_NODE_COUNT: prdata = CSR_DATA_BITS'(node_count_ff);
         default:        prdata = '0;
      endcase
   end

   assign pready         = 1'b1;
   assign cfg.branching  = branching_ff;
   assign cfg.node_count = node_count_ff;
   // a new branching value means every stored parent must be recomputed
   assign cfg.rebuild    = wr_en & (sel == REG_BRANCHING);

endmodule

`default_nettype wire

// ----- sv/thl_pgen.sv -----
// thl_pgen: running parent index generator for the table sweep, (k-1)/branching
// kept as quotient and remainder, no divider; depends on thl_pkg
`default_nettype none

module thl_pgen (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic                              step,
   input  wire logic [thl_pkg::BRANCH_BITS-1:0]   branching,
   output logic      [thl_pkg::NODE_BITS-1:0]     parent
);
   import thl_pkg::*;

   logic                   first_ff, first_in;
   logic [NODE_BITS-1:0]   quot_ff, quot_in;
   logic [BRANCH_BITS-1:0] rem_ff, rem_in;
   logic [BRANCH_BITS-1:0] div_eff;

   // zero branching acts as a chain
   assign div_eff = (branching == '0) ? BRANCH_BITS'(1) : branching;

   always_comb begin
      first_in = first_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      if (start) begin
         first_in = 1'b1;
         quot_in  = '0;
         rem_in   = '0;
      end else if (step) begin
         if (first_ff) begin
            // node 0 to node 1: k-1 becomes 0
            first_in = 1'b0;
         end else if ({1'b0, rem_ff} + (BRANCH_BITS+1)'(1) == {1'b0, div_eff}) begin
            rem_in  = '0;
            quot_in = quot_ff + NODE_BITS'(1);
         end else begin
            rem_in = rem_ff + BRANCH_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
         quot_ff  <= '0;
         rem_ff   <= '0;
      end else begin
         first_ff <= first_in;
         quot_ff  <= quot_in;
         rem_ff   <= rem_in;
      end
   end

   assign parent = quot_ff;

endmodule

`default_nettype wire

// ----- sv/thl_engine.sv -----
// thl_engine: node table and owner memories with the walk sequencer
// depends on thl_pkg and thl_pgen
`default_nettype none

module thl_engine (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire thl_pkg::cfg_type                  cfg,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_kind,
   input  wire logic [thl_pkg::NODE_BITS-1:0]     req_node_index,
   input  wire logic [thl_pkg::USER_BITS-1:0]     req_user_id,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_granted
);
   import thl_pkg::*;

   // memories
   node_word_type        node_mem [MAX_NODES];
   logic [USER_BITS-1:0] owner_mem [MAX_NODES];

   node_word_type        node_rd_ff;
   logic [USER_BITS-1:0] owner_rd_ff;
   logic                 node_we;
   logic [NODE_BITS-1:0] node_waddr;
   node_word_type        node_wdata;
   logic [NODE_BITS-1:0] node_raddr;
   logic                 owner_we;

   state_type             state_ff, state_in;
   logic [SWEEP_BITS-1:0] sweep_ff, sweep_in;
   logic                  wv_ff, wv_in;
   logic [NODE_BITS-1:0]  widx_ff, widx_in;
   logic                  clear_ff, clear_in;
   logic                  kind_ff, kind_in;
   logic [NODE_BITS-1:0]  idx_ff, idx_in;
   logic [USER_BITS-1:0]  uid_ff, uid_in;
   logic [NODE_BITS-1:0]  cur_ff, cur_in;
   logic                  at_item_ff, at_item_in;
   logic                  result_ff, result_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_granted_ff, rsp_granted_in;

   logic                  accept;
   logic                  adjust_now;
   node_word_type         adj_word;
   logic                  pgen_start;
   logic                  pgen_step;
   logic [NODE_BITS-1:0]  pgen_parent;

   thl_pgen u_pgen (
      .clock     (clock),
      .reset     (reset),
      .start     (pgen_start),
      .step      (pgen_step),
      .branching (cfg.branching),
      .parent    (pgen_parent)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[node_waddr] <= node_wdata;
      end
      node_rd_ff <= node_mem[node_raddr];
   end

   always_ff @(posedge clock) begin
      if (owner_we) begin
         owner_mem[idx_ff] <= uid_ff;
      end
      if (accept) begin
         owner_rd_ff <= owner_mem[req_node_index];
      end
   end

   // one step of the counting walk on the entry just read
   always_comb begin
      adj_word.parent = node_rd_ff.parent;
      adj_word.held   = at_item_ff ? (kind_ff == KIND_LOCK) : node_rd_ff.held;
      if (kind_ff == KIND_LOCK) begin
         adj_word.count = node_rd_ff.count + COUNT_BITS'(1);
      end else if (node_rd_ff.count != '0) begin
         adj_word.count = node_rd_ff.count - COUNT_BITS'(1);
      end else begin
         adj_word.count = '0;
      end
   end

   always_comb begin
      state_in       = state_ff;
      sweep_in       = sweep_ff;
      wv_in          = wv_ff;
      widx_in        = widx_ff;
      clear_in       = clear_ff;
      kind_in        = kind_ff;
      idx_in         = idx_ff;
      uid_in         = uid_ff;
      cur_in         = cur_ff;
      at_item_in     = at_item_ff;
      result_in      = result_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_granted_in = rsp_granted_ff;
      node_we        = 1'b0;
      node_waddr     = cur_ff;
      node_wdata     = adj_word;
      node_raddr     = cur_ff;
      owner_we       = 1'b0;
      adjust_now     = 1'b0;
      pgen_start     = 1'b0;
      pgen_step      = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_SWEEP: begin
            if (!sweep_ff[SWEEP_BITS-1]) begin
               node_raddr = sweep_ff[NODE_BITS-1:0];
               sweep_in   = sweep_ff + SWEEP_BITS'(1);
               wv_in      = 1'b1;
               widx_in    = sweep_ff[NODE_BITS-1:0];
            end else begin
               wv_in = 1'b0;
            end
            if (wv_ff) begin
               node_we           = 1'b1;
               node_waddr        = widx_ff;
               node_wdata.parent = pgen_parent;
               node_wdata.held   = clear_ff ? 1'b0 : node_rd_ff.held;
               node_wdata.count  = clear_ff ? '0 : node_rd_ff.count;
               pgen_step         = 1'b1;
               if (sweep_ff[SWEEP_BITS-1]) begin
                  clear_in = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_IDLE: begin
            if (accept) begin
               kind_in    = req_kind;
               idx_in     = req_node_index;
               uid_in     = req_user_id;
               cur_in     = req_node_index;
               at_item_in = 1'b1;
               node_raddr = req_node_index;
               if ({1'b0, req_node_index} < cfg.node_count) begin
                  state_in = ST_FIRST;
               end else begin
                  result_in = 1'b0;
                  state_in  = ST_FINISH;
               end
            end
         end
         ST_FIRST: begin
            if (kind_ff == KIND_LOCK) begin
               if (node_rd_ff.held || node_rd_ff.count != '0) begin
                  result_in = 1'b0;
                  state_in  = ST_FINISH;
               end else if (cur_ff == '0) begin
                  adjust_now = 1'b1;
               end else begin
                  node_raddr = node_rd_ff.parent;
                  cur_in     = node_rd_ff.parent;
                  state_in   = ST_CHECK;
               end
            end else begin
               if (node_rd_ff.held && owner_rd_ff == uid_ff) begin
                  adjust_now = 1'b1;
               end else begin
                  result_in = 1'b0;
                  state_in  = ST_FINISH;
               end
            end
         end
         ST_CHECK: begin
            if (node_rd_ff.held) begin
               result_in = 1'b0;
               state_in  = ST_FINISH;
            end else if (cur_ff == '0) begin
               // path is free, walk again from the node to count it in
               node_raddr = idx_ff;
               cur_in     = idx_ff;
               at_item_in = 1'b1;
               state_in   = ST_ADJUST;
            end else begin
               node_raddr = node_rd_ff.parent;
               cur_in     = node_rd_ff.parent;
            end
         end
         ST_ADJUST: begin
            adjust_now = 1'b1;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = result_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (adjust_now) begin
         node_we    = 1'b1;
         node_waddr = cur_ff;
         node_wdata = adj_word;
         owner_we   = at_item_ff & (kind_ff == KIND_LOCK);
         at_item_in = 1'b0;
         if (cur_ff == '0) begin
            result_in = 1'b1;
            state_in  = ST_FINISH;
         end else begin
            node_raddr = node_rd_ff.parent;
            cur_in     = node_rd_ff.parent;
            state_in   = ST_ADJUST;
         end
      end

      // new branching: restart the parent sweep
      if (cfg.rebuild) begin
         state_in   = ST_SWEEP;
         sweep_in   = '0;
         wv_in      = 1'b0;
         pgen_start = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         wv_ff        <= 1'b0;
         clear_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         wv_ff        <= wv_in;
         clear_ff     <= clear_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      widx_ff        <= widx_in;
      kind_ff        <= kind_in;
      idx_ff         <= idx_in;
      uid_ff         <= uid_in;
      cur_ff         <= cur_in;
      at_item_ff     <= at_item_in;
      result_ff      <= result_in;
      rsp_granted_ff <= rsp_granted_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_granted = rsp_granted_ff;

endmodule

`default_nettype wire

// ----- sv/thl_checker.sv -----
// thl_checker: port-level checks of the tree hierarchical lock unit, bound to the top
// depends on thl_pkg
`default_nettype none

module thl_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire logic                              req_stall,
   input  wire logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   input  wire logic                              rsp_granted,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [thl_pkg::CSR_ADDR_BITS-1:0] paddr
);
   import thl_pkg::*;

   // table sweep follows reset, and no response is left over
   a_reset_sweep: assert property (@(posedge clock)
      reset |=> req_stall && !rsp_valid)
      else $error("no sweep or stray response after reset");

   // one request in work at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while another is in work");

   // new branching rebuilds the table before the next request
   a_rebuild: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && paddr[2] == REG_BRANCHING) |=> req_stall)
      else $error("branching write did not start a rebuild");

   // held response beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_granted))
      else $error("stalled response changed");

endmodule

bind tree_hierarchical_lock_unit thl_checker u_thl_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_granted (rsp_granted),
   .psel        (psel),
   .penable     (penable),
   .pwrite      (pwrite),
   .paddr       (paddr)
);

`default_nettype wire
